[design/sfc_pkg.sv]
// Shared types and codes for the score filter compactor.
package sfc_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int MAX_MEDOIDS = 64;

   localparam logic [1:0] CMD_LOAD_POINT  = 2'd0;
   localparam logic [1:0] CMD_LOAD_MEDOID = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;
   localparam logic [1:0] CMD_FETCH       = 2'd3;

   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_POINT   = 2'd1;
   localparam logic [1:0] KIND_MEDOID  = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [1:0] REG_FILTER_MODE       = 2'd0;
   localparam logic [1:0] REG_SCORE_THRESHOLD   = 2'd1;
   localparam logic [1:0] REG_QUANTILE_FRACTION = 2'd2;

   localparam logic [15:0] QUANTILE_RESET = 16'd13107;

   typedef struct packed {
      logic               filter_mode;
      logic signed [15:0] score_threshold;
      logic [15:0]        quantile_fraction;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         point_index;
      logic [15:0]        cluster_out;
      logic [10:0]        new_index;
      logic signed [15:0] threshold_used;
      logic [10:0]        remain_count;
      logic [6:0]         forced_count;
      logic               last;
      logic               error;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Q_MUL,
      ST_Q_K,
      ST_Q_STEP,
      ST_Q_PASS,
      ST_Q_UPD,
      ST_MARK,
      ST_FORCE_RD,
      ST_FORCE_CHK,
      ST_FORCE_UPD,
      ST_RANK,
      ST_FETCH_RD,
      ST_FETCH_CHK,
      ST_MED_CHK,
      ST_MED_FIN,
      ST_EMIT
   } state_type;

endpackage

[design/sfc_csr.sv]
// Configuration register file behind the APB-style port.
module sfc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output sfc_pkg::cfg_type cfg
);
   import sfc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FILTER_MODE:       cfg_in.filter_mode = pwdata[0];
            REG_SCORE_THRESHOLD:   cfg_in.score_threshold = $signed(pwdata[15:0]);
            REG_QUANTILE_FRACTION: cfg_in.quantile_fraction = pwdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FILTER_MODE:       prdata = {31'd0, cfg_ff.filter_mode};
         REG_SCORE_THRESHOLD:   prdata = {16'd0, cfg_ff.score_threshold};
         REG_QUANTILE_FRACTION: prdata = {16'd0, cfg_ff.quantile_fraction};
         default:               prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode       <= 1'b0;
         cfg_ff.score_threshold   <= 16'sd0;
         cfg_ff.quantile_fraction <= QUANTILE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/sfc_core.sv]
// Point and medoid stores with the sequencer that runs the filter and fetches results.
module sfc_core (
   input  logic               clock,
   input  logic               reset,
   input  sfc_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_cmd,
   input  logic signed [15:0] in_score,
   input  logic [15:0]        in_cluster,
   input  logic [10:0]        in_medoid,
   input  logic               out_free,
   output logic               res_valid,
   output sfc_pkg::res_type   res
);
   import sfc_pkg::*;

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int MIW = (MAX_MEDOIDS > 1) ? $clog2(MAX_MEDOIDS) : 1;
   localparam int MCW = $clog2(MAX_MEDOIDS + 1);
   localparam int EW  = (CW > 11) ? CW : 11;
   localparam int PRW = 16 + CW;

   // stores
   logic signed [15:0] score_mem   [MAX_POINTS];
   logic [15:0]        cluster_mem [MAX_POINTS];
   logic               keep_mem    [MAX_POINTS];
   logic [CW-1:0]      rank_mem    [MAX_POINTS];
   logic [10:0]        medoid_mem  [MAX_MEDOIDS];

   logic signed [15:0] score_rd_ff;
   logic [15:0]        cluster_rd_ff;
   logic               keep_rd_ff;
   logic [CW-1:0]      rank_rd_ff;
   logic [10:0]        medoid_rd_ff;

   logic [PW-1:0]  point_waddr, score_raddr, keep_raddr, keep_waddr, rank_waddr, rank_raddr;
   logic [MIW-1:0] medoid_waddr, medoid_raddr;
   logic           point_we, medoid_we, keep_we, keep_wdata, rank_we;

   state_type state_ff, state_in;

   logic [CW-1:0]      pc_ff, pc_in, fcur_ff, fcur_in, compact_ff, compact_in;
   logic [CW-1:0]      remain_ff, remain_in, cnt_ff, cnt_in, k_ff, k_in;
   logic [MCW-1:0]     mc_ff, mc_in, mcur_ff, mcur_in, t_ff, t_in, forced_ff, forced_in;
   logic               ovf_ff, ovf_in, ran_ff, ran_in, err_ff, err_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               scan_pend_ff, scan_pend_in;
   logic [PW-1:0]      scan_pidx_ff, scan_pidx_in, fm_ff, fm_in;
   logic signed [15:0] thr_ff, thr_in, lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [PRW-1:0]     prod_ff, prod_in;
   logic               mok_ff, mok_in;
   logic [9:0]         mpidx_ff, mpidx_in;
   res_type            res_ff, res_in;

   logic           scan_issue, scan_done, med_ok, pc_full;
   logic [CW-1:0]  load_base, k_raw, cnt_step;
   logic [MCW-1:0] med_base;
   logic [PRW-1:0] k_sum;
   logic [16:0]    lohi_sum;
   logic [10:0]    med_dec;

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_EMIT) && out_free;
   assign res       = res_ff;

   assign scan_issue = scan_idx_ff < pc_ff;
   assign scan_done  = !scan_issue && !scan_pend_ff;
   assign med_ok     = (medoid_rd_ff != 11'd0) && (EW'(medoid_rd_ff) <= EW'(pc_ff));
   assign med_dec    = medoid_rd_ff - 11'd1;
   assign load_base  = ran_ff ? '0 : pc_ff;
   assign med_base   = ran_ff ? '0 : mc_ff;
   assign pc_full    = load_base >= CW'(MAX_POINTS);
   assign k_sum      = prod_ff + PRW'(32768);
   assign k_raw      = k_sum[PRW-1:16];
   assign lohi_sum   = $signed({lo_ff[15], lo_ff}) + $signed({hi_ff[15], hi_ff});
   assign cnt_step   = cnt_ff + CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               unique case (in_cmd)
                  CMD_RUN:   state_in = (cfg.filter_mode && pc_ff != '0) ? ST_Q_MUL : ST_MARK;
                  CMD_FETCH: state_in = ran_ff ? ST_FETCH_RD : ST_EMIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_Q_MUL:     state_in = ST_Q_K;
         ST_Q_K:       state_in = ST_Q_STEP;
         ST_Q_STEP:    state_in = (lo_ff < hi_ff) ? ST_Q_PASS : ST_MARK;
         ST_Q_PASS:    state_in = scan_done ? ST_Q_UPD : ST_Q_PASS;
         ST_Q_UPD:     state_in = ST_Q_STEP;
         ST_MARK:      state_in = scan_done ? ST_FORCE_RD : ST_MARK;
         ST_FORCE_RD:  state_in = (t_ff < mc_ff) ? ST_FORCE_CHK : ST_RANK;
         ST_FORCE_CHK: state_in = med_ok ? ST_FORCE_UPD : ST_FORCE_RD;
         ST_FORCE_UPD: state_in = ST_FORCE_RD;
         ST_RANK:      state_in = scan_done ? ST_EMIT : ST_RANK;
         ST_FETCH_RD: begin
            priority if (fcur_ff < pc_ff) state_in = ST_FETCH_CHK;
            else if (mcur_ff < mc_ff)     state_in = ST_MED_CHK;
            else                          state_in = ST_EMIT;
         end
         ST_FETCH_CHK: state_in = keep_rd_ff ? ST_EMIT : ST_FETCH_RD;
         ST_MED_CHK:   state_in = ST_MED_FIN;
         ST_MED_FIN:   state_in = ST_EMIT;
         ST_EMIT:      state_in = out_free ? ST_IDLE : ST_EMIT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and store controls
   always_comb begin
      pc_in = pc_ff;  mc_in = mc_ff;  fcur_in = fcur_ff;  mcur_in = mcur_ff;
      compact_in = compact_ff;  remain_in = remain_ff;  cnt_in = cnt_ff;  k_in = k_ff;
      t_in = t_ff;  forced_in = forced_ff;  ovf_in = ovf_ff;  ran_in = ran_ff;
      err_in = err_ff;  thr_in = thr_ff;  lo_in = lo_ff;  hi_in = hi_ff;  mid_in = mid_ff;
      prod_in = prod_ff;  fm_in = fm_ff;  mok_in = mok_ff;  mpidx_in = mpidx_ff;
      res_in = res_ff;
      point_we = 1'b0;  medoid_we = 1'b0;  keep_we = 1'b0;  rank_we = 1'b0;
      keep_wdata = 1'b0;
      point_waddr  = load_base[PW-1:0];
      medoid_waddr = med_base[MIW-1:0];
      score_raddr  = scan_idx_ff[PW-1:0];
      keep_raddr   = scan_idx_ff[PW-1:0];
      keep_waddr   = scan_pidx_ff;
      rank_waddr   = scan_pidx_ff;
      rank_raddr   = med_dec[PW-1:0];
      medoid_raddr = t_ff[MIW-1:0];

      // scan passes walk 0..n-1 with one read in flight
      if (state_ff == ST_Q_PASS || state_ff == ST_MARK || state_ff == ST_RANK) begin
         scan_idx_in  = scan_idx_ff + CW'(scan_issue);
         scan_pend_in = scan_issue;
         scan_pidx_in = scan_idx_ff[PW-1:0];
      end else begin
         scan_idx_in  = '0;
         scan_pend_in = 1'b0;
         scan_pidx_in = scan_pidx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               unique case (in_cmd)
                  CMD_LOAD_POINT, CMD_LOAD_MEDOID: begin
                     if (ran_ff) begin
                        pc_in  = '0;
                        mc_in  = '0;
                        ovf_in = 1'b0;
                        ran_in = 1'b0;
                     end
                     if (in_cmd == CMD_LOAD_POINT) begin
                        if (pc_full) ovf_in = 1'b1;
                        else begin
                           point_we = 1'b1;
                           pc_in    = load_base + CW'(1);
                        end
                     end else begin
                        if (med_base >= MCW'(MAX_MEDOIDS)) ovf_in = 1'b1;
                        else begin
                           medoid_we = 1'b1;
                           mc_in     = med_base + MCW'(1);
                        end
                     end
                  end
                  CMD_RUN: begin
                     thr_in    = cfg.filter_mode ? 16'sd0 : cfg.score_threshold;
                     err_in    = ovf_ff;
                     forced_in = '0;
                     t_in      = '0;
                  end
                  default: begin
                     res_in      = '0;
                     res_in.kind = KIND_NONE;
                     res_in.last = 1'b1;
                  end
               endcase
            end
         end
         ST_Q_MUL: prod_in = PRW'(cfg.quantile_fraction) * PRW'(pc_ff);
         ST_Q_K: begin
            k_in  = (k_raw >= pc_ff) ? pc_ff - CW'(1) : k_raw;
            lo_in = -16'sd32768;
            hi_in = 16'sd32767;
         end
         ST_Q_STEP: begin
            mid_in = $signed(lohi_sum[16:1]);
            cnt_in = '0;
            if (!(lo_ff < hi_ff)) thr_in = lo_ff;
         end
         ST_Q_PASS: begin
            if (scan_pend_ff && score_rd_ff <= mid_ff) cnt_in = cnt_step;
         end
         ST_Q_UPD: begin
            // smallest value with more than k scores at or below it
            if (cnt_ff > k_ff) hi_in = mid_ff;
            else               lo_in = mid_ff + 16'sd1;
         end
         ST_MARK: begin
            keep_we    = scan_pend_ff;
            keep_wdata = score_rd_ff >= thr_ff;
            cnt_in     = '0;
         end
         ST_FORCE_RD: cnt_in = '0;
         ST_FORCE_CHK: begin
            keep_raddr = med_dec[PW-1:0];
            fm_in      = med_dec[PW-1:0];
            if (!med_ok) begin
               err_in = 1'b1;
               t_in   = t_ff + MCW'(1);
            end
         end
         ST_FORCE_UPD: begin
            keep_waddr = fm_ff;
            keep_wdata = 1'b1;
            if (!keep_rd_ff) begin
               keep_we   = 1'b1;
               forced_in = forced_ff + MCW'(1);
            end
            t_in = t_ff + MCW'(1);
         end
         ST_RANK: begin
            // rank = kept points ahead of this one
            rank_we = scan_pend_ff;
            if (scan_pend_ff && keep_rd_ff) cnt_in = cnt_step;
            if (scan_done) begin
               remain_in  = cnt_ff;
               fcur_in    = '0;
               compact_in = '0;
               mcur_in    = '0;
               ran_in     = 1'b1;
               res_in                = '0;
               res_in.kind           = KIND_SUMMARY;
               res_in.threshold_used = thr_ff;
               res_in.remain_count   = 11'(cnt_ff);
               res_in.forced_count   = 7'(forced_ff);
               res_in.last           = (cnt_ff == '0) && (mc_ff == '0);
               res_in.error          = err_ff;
            end
         end
         ST_FETCH_RD: begin
            keep_raddr   = fcur_ff[PW-1:0];
            score_raddr  = fcur_ff[PW-1:0];
            medoid_raddr = mcur_ff[MIW-1:0];
            if (!(fcur_ff < pc_ff) && !(mcur_ff < mc_ff)) begin
               res_in      = '0;
               res_in.kind = KIND_NONE;
               res_in.last = 1'b1;
            end
         end
         ST_FETCH_CHK: begin
            fcur_in = fcur_ff + CW'(1);
            if (keep_rd_ff) begin
               compact_in         = compact_ff + CW'(1);
               res_in             = '0;
               res_in.kind        = KIND_POINT;
               res_in.point_index = 10'(fcur_ff);
               res_in.cluster_out = cluster_rd_ff;
               res_in.new_index   = 11'(compact_ff + CW'(1));
               res_in.last        = (compact_ff + CW'(1) == remain_ff) && (mc_ff == '0);
            end
         end
         ST_MED_CHK: begin
            mok_in   = med_ok;
            mpidx_in = 10'(med_dec);
         end
         ST_MED_FIN: begin
            mcur_in            = mcur_ff + MCW'(1);
            res_in             = '0;
            res_in.kind        = KIND_MEDOID;
            res_in.point_index = mok_ff ? mpidx_ff : 10'd0;
            res_in.new_index   = mok_ff ? 11'(rank_rd_ff + CW'(1)) : 11'd0;
            res_in.last        = (mcur_ff + MCW'(1)) == mc_ff;
            res_in.error       = !mok_ff;
         end
         ST_EMIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (point_we) begin
         score_mem[point_waddr]   <= in_score;
         cluster_mem[point_waddr] <= in_cluster;
      end
      if (medoid_we) medoid_mem[medoid_waddr] <= in_medoid;
      if (keep_we)   keep_mem[keep_waddr] <= keep_wdata;
      if (rank_we)   rank_mem[rank_waddr] <= cnt_ff;
      score_rd_ff   <= score_mem[score_raddr];
      cluster_rd_ff <= cluster_mem[score_raddr];
      keep_rd_ff    <= keep_mem[keep_raddr];
      rank_rd_ff    <= rank_mem[rank_raddr];
      medoid_rd_ff  <= medoid_mem[medoid_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         mc_ff        <= '0;
         fcur_ff      <= '0;
         mcur_ff      <= '0;
         compact_ff   <= '0;
         remain_ff    <= '0;
         ovf_ff       <= 1'b0;
         ran_ff       <= 1'b0;
         scan_idx_ff  <= '0;
         scan_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         mc_ff        <= mc_in;
         fcur_ff      <= fcur_in;
         mcur_ff      <= mcur_in;
         compact_ff   <= compact_in;
         remain_ff    <= remain_in;
         ovf_ff       <= ovf_in;
         ran_ff       <= ran_in;
         scan_idx_ff  <= scan_idx_in;
         scan_pend_ff <= scan_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      t_ff         <= t_in;
      forced_ff    <= forced_in;
      err_ff       <= err_in;
      thr_ff       <= thr_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      prod_ff      <= prod_in;
      fm_ff        <= fm_in;
      mok_ff       <= mok_in;
      mpidx_ff     <= mpidx_in;
      scan_pidx_ff <= scan_pidx_in;
      res_ff       <= res_in;
   end

endmodule

[design/score_filter_compactor.sv]
// Top level of the score filter compactor: stream ports, result register, config port.
//
// A load leaves the block in its idle state, ready again for the next command. A run
// command is one sequencer walking the point store with a single compare/count unit:
// in quantile mode with points loaded, a setup of the quantile rank and 16 binary-search
// passes over the store, then a mark pass, a force step for each medoid and a rank pass.
// A fetch steps over dropped points to the next kept one, else renumbers the next medoid,
// else returns a nothing-left result, as it also does before any run. Results sit in an
// output register so the next command can be taken while a result waits; the block then
// holds in its emit step only if a second result is ready before the first is taken.
module score_filter_compactor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // score[15:0], cluster_id[31:16], medoid_point[42:32]
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // point_index, cluster_out, new_index, threshold_used,
                                    // remain_count, forced_count, error
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sfc_pkg::*;

   cfg_type cfg;
   res_type res, rsp_ff, rsp_in;
   logic    res_valid, out_free, rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   sfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   sfc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_score   ($signed(req_tdata[15:0])),
      .in_cluster (req_tdata[31:16]),
      .in_medoid  (req_tdata[42:32]),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.error, rsp_ff.forced_count, rsp_ff.remain_count,
                        rsp_ff.threshold_used, rsp_ff.new_index, rsp_ff.cluster_out,
                        rsp_ff.point_index};

endmodule

[design/sfc_checker.sv]
// Port-level checks for the score filter compactor, bound to the top level.
module sfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import sfc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_NONE |-> rsp_tlast && rsp_tdata == 72'd0)
      else $error("nothing-left beat malformed");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == CMD_LOAD_POINT || req_tuser == CMD_LOAD_MEDOID) |=> !$rose(rsp_tvalid))
      else $error("load produced a result");

   a_summary_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SUMMARY |-> rsp_tdata[36:0] == 37'd0)
      else $error("summary carries point fields");

endmodule

bind score_filter_compactor sfc_checker u_sfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[sim/sfc_checker.sv]
// Stream monitor, prediction and result compare for the score filter compactor.
module sfc_scoreboard
   import sfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending,
   output int          result_count
);

   localparam int NPTS = 1024;
   localparam int NMEDS = 64;

   cfg_type            cfg;
   logic signed [15:0] pt_score [NPTS];
   logic [15:0]        pt_cluster [NPTS];
   bit                 keep [NPTS];
   logic signed [15:0] sorted [NPTS];
   int                 rank_before [NPTS+1];
   logic [10:0]        med_pt [NMEDS];
   logic [10:0]        med_rank [NMEDS];
   int                 n_pts, n_meds, cursor, compacted, med_cursor, remain;
   bit                 overflow, ran;
   res_type            expected_q [$];

   assign pending = expected_q.size();

   function automatic bit medoid_in_range(logic [10:0] m);
      return m >= 1 && m <= n_pts;
   endfunction

   function automatic void start_batch();
      n_pts = 0; n_meds = 0; cursor = 0; compacted = 0; med_cursor = 0;
      remain = 0; overflow = 0; ran = 0;
      foreach (keep[i]) keep[i] = 0;
      foreach (med_rank[i]) med_rank[i] = '0;
   endfunction

   function automatic logic signed [15:0] quantile_score();
      int j;
      longint k;
      logic signed [15:0] v;
      if (n_pts == 0) return '0;
      for (int i = 0; i < n_pts; i++) begin
         v = pt_score[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      k = (longint'(cfg.quantile_fraction) * n_pts + 32768) >> 16;
      if (k > n_pts - 1) k = n_pts - 1;
      return sorted[k];
   endfunction

   function automatic res_type run_filter();
      res_type r;
      logic signed [15:0] thr;
      int forced;
      bit err;
      r = '0;
      thr = cfg.filter_mode ? quantile_score() : cfg.score_threshold;
      forced = 0;
      err = overflow;
      for (int i = 0; i < n_pts; i++) keep[i] = pt_score[i] >= thr;
      for (int t = 0; t < n_meds; t++) begin
         if (!medoid_in_range(med_pt[t])) err = 1;
         else if (!keep[med_pt[t]-1]) begin
            keep[med_pt[t]-1] = 1;
            forced++;
         end
      end
      rank_before[0] = 0;
      for (int i = 0; i < n_pts; i++) rank_before[i+1] = rank_before[i] + keep[i];
      remain = rank_before[n_pts];
      for (int t = 0; t < n_meds; t++)
         med_rank[t] = medoid_in_range(med_pt[t]) ? 11'(rank_before[med_pt[t]-1] + 1) : '0;
      cursor = 0; compacted = 0; med_cursor = 0; ran = 1;
      r.kind = KIND_SUMMARY;
      r.threshold_used = thr;
      r.remain_count = 11'(remain);
      r.forced_count = 7'(forced);
      r.last = remain == 0 && n_meds == 0;
      r.error = err;
      return r;
   endfunction

   function automatic res_type fetch_next();
      res_type r;
      bit ok;
      r = '0;
      r.kind = KIND_NONE;
      r.last = 1;
      if (ran) begin
         while (cursor < n_pts && !keep[cursor]) cursor++;
         if (cursor < n_pts) begin
            compacted++;
            r.kind = KIND_POINT;
            r.point_index = 10'(cursor);
            r.cluster_out = pt_cluster[cursor];
            r.new_index = 11'(compacted);
            r.last = compacted == remain && n_meds == 0;
            cursor++;
         end else if (med_cursor < n_meds) begin
            ok = medoid_in_range(med_pt[med_cursor]);
            r.kind = KIND_MEDOID;
            r.point_index = ok ? 10'(med_pt[med_cursor] - 1) : '0;
            r.new_index = ok ? med_rank[med_cursor] : '0;
            med_cursor++;
            r.last = med_cursor == n_meds;
            r.error = !ok;
         end
      end
      return r;
   endfunction

   function automatic void take_command(logic [1:0] cmd, logic [47:0] d);
      if (cmd == CMD_LOAD_POINT || cmd == CMD_LOAD_MEDOID) begin
         if (ran) start_batch();
         if (cmd == CMD_LOAD_POINT) begin
            if (n_pts < NPTS) begin
               pt_score[n_pts] = d[15:0];
               pt_cluster[n_pts] = d[31:16];
               keep[n_pts] = 0;
               n_pts++;
            end else overflow = 1;
         end else begin
            if (n_meds < NMEDS) begin
               med_pt[n_meds] = d[42:32];
               n_meds++;
            end else overflow = 1;
         end
      end else if (cmd == CMD_RUN) expected_q.insert(expected_q.size(), run_filter());
      else expected_q.insert(expected_q.size(), fetch_next());
   endfunction

   always @(posedge clock) begin
      res_type got, want;
      if (reset) begin
         cfg.filter_mode <= 1'b0;
         cfg.score_threshold <= '0;
         cfg.quantile_fraction <= QUANTILE_RESET;
         start_batch();
         expected_q.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_FILTER_MODE:       cfg.filter_mode <= csr_pwdata[0];
               REG_SCORE_THRESHOLD:   cfg.score_threshold <= csr_pwdata[15:0];
               REG_QUANTILE_FRACTION: cfg.quantile_fraction <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         // older result beat is checked before this edge's command is predicted
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            got.kind = rsp_tuser;
            got.point_index = rsp_tdata[9:0];
            got.cluster_out = rsp_tdata[25:10];
            got.new_index = rsp_tdata[36:26];
            got.threshold_used = rsp_tdata[52:37];
            got.remain_count = rsp_tdata[63:53];
            got.forced_count = rsp_tdata[70:64];
            got.error = rsp_tdata[71];
            got.last = rsp_tlast;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p", $time, want);
                  $display("%0t:          actual   %p", $time, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) take_command(req_tuser, req_tdata);
      end
   end

endmodule

[sim/tb.sv]
// Stimulus and verdict for the score filter compactor regression.
module tb;
   import sfc_pkg::*;

   localparam int LIMIT = 3000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_FETCH;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending, result_count;
   int cycles = 0;
   int items_sent = 0;
   int batches = 0;
   bit calm = 0;
   bit held = 0;

   score_filter_compactor dut (.*);

   sfc_scoreboard chk (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("score_filter_compactor regression: fail");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      int gap, beats;
      beats = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 7);
         // lands inside the directed fetch burst, so the sender keeps offering
         if (beats == 6 && !held) begin
            held = 1;
            gap = 400;
         end
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         beats++;
      end
   end

   task automatic send(logic [1:0] cmd, logic [15:0] score, logic [15:0] cluster,
                       logic [10:0] medoid);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, medoid, cluster, score};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
   endtask

   // quiet the input, drain results, then let trailing loads settle
   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_score();
      case ($urandom_range(0, 9))
         0: return -16'sd16384;
         1: return 16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [10:0] pick_medoid(int n);
      case ($urandom_range(0, 11))
         0: return '0;
         1: return 11'($urandom_range(n + 1, 2047));
         default: return 11'($urandom_range(1, n > 0 ? n : 1));
      endcase
   endfunction

   task automatic batch(int n, int m, int fetches);
      int p, q;
      p = 0;
      q = 0;
      while (p < n || q < m) begin
         if (q < m && (p >= n || $urandom_range(0, 3) == 0)) begin
            send(CMD_LOAD_MEDOID, 16'($urandom), 16'($urandom), pick_medoid(n));
            q++;
         end else begin
            send(CMD_LOAD_POINT, pick_score(), 16'($urandom), 11'($urandom));
            p++;
         end
      end
      send(CMD_RUN, 16'($urandom), 16'($urandom), 11'($urandom));
      for (int f = 0; f < fetches; f++) begin
         // occasional rerun mid-fetch restarts the sequence
         if ($urandom_range(0, 40) == 0)
            send(CMD_RUN, '0, '0, '0);
         send(CMD_FETCH, 16'($urandom), 16'($urandom), 11'($urandom));
      end
      batches++;
   endtask

   task automatic random_config();
      csr_write(REG_FILTER_MODE, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
         0: csr_write(REG_SCORE_THRESHOLD, 32'hFFFF_C000);
         1: csr_write(REG_SCORE_THRESHOLD, 32'd16384);
         default: csr_write(REG_SCORE_THRESHOLD,
                            32'($signed($urandom_range(0, 32768)) - 16384));
      endcase
      case ($urandom_range(0, 3))
         0: csr_write(REG_QUANTILE_FRACTION, 32'd1);
         1: csr_write(REG_QUANTILE_FRACTION, 32'd65535);
         default: csr_write(REG_QUANTILE_FRACTION, 32'($urandom_range(1, 65535)));
      endcase
   endtask

   initial begin
      int n, m;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: empty runs, extremes, bad and duplicate medoids
      send(CMD_FETCH, '0, '0, '0);
      send(CMD_RUN, '0, '0, '0);
      send(CMD_FETCH, '0, '0, '0);
      drain();
      csr_write(REG_FILTER_MODE, 32'd1);
      send(CMD_RUN, '0, '0, '0);
      send(CMD_LOAD_POINT, 16'hC000, 16'h0000, '0);
      send(CMD_LOAD_POINT, 16'h4000, 16'hFFFF, '0);
      send(CMD_LOAD_POINT, 16'h0000, 16'h5A5A, '0);
      send(CMD_LOAD_MEDOID, '0, '0, 11'd0);
      send(CMD_LOAD_MEDOID, '0, '0, 11'd1);
      send(CMD_LOAD_MEDOID, '0, '0, 11'd1);
      send(CMD_LOAD_MEDOID, '0, '0, 11'd4);
      send(CMD_RUN, '0, '0, '0);
      repeat (8) send(CMD_FETCH, '0, '0, '0);
      drain();
      csr_write(REG_FILTER_MODE, 32'd0);
      csr_write(REG_SCORE_THRESHOLD, 32'd16384);
      send(CMD_RUN, '0, '0, '0);
      repeat (3) send(CMD_FETCH, '0, '0, '0);
      drain();

      for (int b = 0; b < 8; b++) begin
         random_config();
         calm = (b % 4) == 3;
         if (b == 5) begin
            // full stores plus overflow on both, medoid index at the top
            batch(1026, 66, 60);
         end else begin
            n = $urandom_range(0, 8);
            m = $urandom_range(0, 4);
            batch(n, m, n + m + $urandom_range(0, 2));
         end
         drain();
      end
      calm = 0;
      drain();

      $display("covered %0d batches, %0d command beats, %0d result beats",
               batches, items_sent, result_count);
      $display("both filter modes, store overflow, bad and duplicate medoids, reruns");
      if (fail_count == 0)
         $display("score_filter_compactor regression: pass");
      else
         $display("score_filter_compactor regression: fail");
      $finish;
   end

endmodule

[filelist.f]
design/sfc_pkg.sv
design/sfc_csr.sv
design/sfc_core.sv
design/score_filter_compactor.sv
design/sfc_checker.sv
sim/sfc_checker.sv
sim/tb.sv
